// ----- src/fptbl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fptbl_pkg
// Shared types and codes of the five-tuple flow to process table.
// ----------------------------------------------------------------------------
package fptbl_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int PROTO_W = 8;
    localparam int ADDR_W  = 64;
    localparam int PORT_W  = 16;
    localparam int PID_W   = 32;

    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_MISS = 2'd1;
    localparam logic [1:0] STS_FULL = 2'd2;

    typedef struct packed {
        logic [PROTO_W-1:0] protocol;
        logic [ADDR_W-1:0]  local_high;
        logic [ADDR_W-1:0]  local_low;
        logic [PORT_W-1:0]  local_port;
        logic [ADDR_W-1:0]  remote_high;
        logic [ADDR_W-1:0]  remote_low;
        logic [PORT_W-1:0]  remote_port;
    } t_key;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

// ----- src/flow_to_process_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// flow_to_process_table
// Bounded five-tuple flow table mapping a flow key to a process number.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one command word: insert or
// overwrite, remove, or lookup of a key. Output channel (o_out_valid /
// i_out_ready) returns exactly one result word per command: the process
// number found and a status.
// The table lives in one memory with a registered read port. A single
// comparator walks it one entry per cycle, and a pass ends early on a hit; a
// UDP lookup that misses takes a second pass with the remote part zeroed. The
// block is not ready while it works on a command, so it takes no new one then.
// After reset a clearing pass writes every valid bit to zero, one entry per
// cycle; no command is taken meanwhile.
// The result sits in an output register; while the receiver stalls, the next
// command is still taken and worked, and its result waits in the block until
// the output register frees up.
// ----------------------------------------------------------------------------
module flow_to_process_table #(
    parameter int TABLE_ENTRIES = fptbl_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_protocol,
    input  wire logic [63:0] i_local_addr_high,
    input  wire logic [63:0] i_local_addr_low,
    input  wire logic [15:0] i_local_port,
    input  wire logic [63:0] i_remote_addr_high,
    input  wire logic [63:0] i_remote_addr_low,
    input  wire logic [15:0] i_remote_port,
    input  wire logic [31:0] i_process_id,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_found_process,
    output logic [1:0]       o_status
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_ENTRIES - 1);

    // table memory
    fptbl_pkg::t_key                  mem_key  [TABLE_ENTRIES];
    logic [fptbl_pkg::PID_W-1:0]      mem_proc [TABLE_ENTRIES];
    logic                             mem_vld  [TABLE_ENTRIES];

    fptbl_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic              r_issue, n_issue;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_last;
    fptbl_pkg::t_key   r_rd_key;
    logic [fptbl_pkg::PID_W-1:0] r_rd_proc;
    logic              r_rd_ok;

    logic [1:0]        r_op, n_op;
    fptbl_pkg::t_key   r_key, n_key;
    logic [fptbl_pkg::PID_W-1:0] r_pid, n_pid;
    logic              r_pass2, n_pass2;
    logic              r_free_found, n_free_found;
    logic [IDX_W-1:0]  r_free_idx, n_free_idx;
    logic [fptbl_pkg::PID_W-1:0] r_res_found, n_res_found;
    logic [1:0]        r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic [fptbl_pkg::PID_W-1:0] r_out_found, n_out_found;
    logic [1:0]        r_out_status, n_out_status;

    logic              rd_en;
    logic              key_we;
    logic              vld_we;
    logic              vld_wdata;
    logic [IDX_W-1:0]  wr_addr;
    logic              cmp_hit;
    logic              cmp_free;
    logic              scan_end;
    logic [IDX_W-1:0]  free_sel;

    assign cmp_hit  = r_rd_vld && r_rd_ok && (r_rd_key == r_key);
    assign cmp_free = r_rd_vld && !r_rd_ok;
    assign scan_end = (r_state == fptbl_pkg::ST_SCAN) && (cmp_hit || (r_rd_vld && r_rd_last));
    assign free_sel = r_free_found ? r_free_idx : r_rd_idx;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue      = r_issue;
        n_op         = r_op;
        n_key        = r_key;
        n_pid        = r_pid;
        n_pass2      = r_pass2;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        key_we       = 1'b0;
        vld_we       = 1'b0;
        vld_wdata    = 1'b0;
        wr_addr      = r_addr;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            fptbl_pkg::ST_CLEAR: begin
                vld_we = 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = fptbl_pkg::ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            fptbl_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op                 = i_operation;
                    n_key.protocol       = i_protocol;
                    n_key.local_high     = i_local_addr_high;
                    n_key.local_low      = i_local_addr_low;
                    n_key.local_port     = i_local_port;
                    n_key.remote_high    = i_remote_addr_high;
                    n_key.remote_low     = i_remote_addr_low;
                    n_key.remote_port    = i_remote_port;
                    n_pid                = i_process_id;
                    n_pass2              = 1'b0;
                    n_free_found         = 1'b0;
                    n_addr               = '0;
                    n_issue              = 1'b1;
                    if (i_operation == fptbl_pkg::OP_INSERT ||
                        i_operation == fptbl_pkg::OP_REMOVE ||
                        i_operation == fptbl_pkg::OP_LOOKUP) begin
                        n_state = fptbl_pkg::ST_SCAN;
                    end else begin
                        n_res_found  = '0;
                        n_res_status = fptbl_pkg::STS_MISS;
                        n_state      = fptbl_pkg::ST_FINISH;
                    end
                end
            end
            fptbl_pkg::ST_SCAN: begin
                rd_en = r_issue && !scan_end;
                if (rd_en) begin
                    if (r_addr == LAST) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (cmp_free && !r_free_found) begin
                    n_free_found = 1'b1;
                    n_free_idx   = r_rd_idx;
                end
                if (scan_end) begin
                    n_state      = fptbl_pkg::ST_FINISH;
                    n_res_found  = '0;
                    n_res_status = fptbl_pkg::STS_MISS;
                    unique case (r_op)
                        fptbl_pkg::OP_INSERT: begin
                            if (cmp_hit) begin
                                key_we       = 1'b1;
                                vld_we       = 1'b1;
                                vld_wdata    = 1'b1;
                                wr_addr      = r_rd_idx;
                                n_res_status = fptbl_pkg::STS_OK;
                            end else if (r_free_found || cmp_free) begin
                                key_we       = 1'b1;
                                vld_we       = 1'b1;
                                vld_wdata    = 1'b1;
                                wr_addr      = free_sel;
                                n_res_status = fptbl_pkg::STS_OK;
                            end else begin
                                n_res_status = fptbl_pkg::STS_FULL;
                            end
                        end
                        fptbl_pkg::OP_REMOVE: begin
                            if (cmp_hit) begin
                                vld_we       = 1'b1;
                                wr_addr      = r_rd_idx;
                                n_res_status = fptbl_pkg::STS_OK;
                            end
                        end
                        fptbl_pkg::OP_LOOKUP: begin
                            if (cmp_hit) begin
                                n_res_found  = r_rd_proc;
                                n_res_status = fptbl_pkg::STS_OK;
                            end else if (r_key.protocol == fptbl_pkg::PROTO_UDP && !r_pass2) begin
                                // udp wildcard retry with the remote part zeroed
                                n_state           = fptbl_pkg::ST_SCAN;
                                n_pass2           = 1'b1;
                                n_key.remote_high = '0;
                                n_key.remote_low  = '0;
                                n_key.remote_port = '0;
                                n_addr            = '0;
                                n_issue           = 1'b1;
                            end
                        end
                        default: begin
                            n_res_status = fptbl_pkg::STS_MISS;
                        end
                    endcase
                end
            end
            fptbl_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_res_found;
                    n_out_status = r_res_status;
                    n_state      = fptbl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fptbl_pkg::ST_IDLE;
            end
        endcase
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_key[wr_addr]  <= r_key;
            mem_proc[wr_addr] <= r_pid;
        end
        if (vld_we) begin
            mem_vld[wr_addr] <= vld_wdata;
        end
        if (rd_en) begin
            r_rd_key  <= mem_key[r_addr];
            r_rd_proc <= mem_proc[r_addr];
            r_rd_ok   <= mem_vld[r_addr];
            r_rd_idx  <= r_addr;
            r_rd_last <= (r_addr == LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fptbl_pkg::ST_CLEAR;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_rd_vld    <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_pid        <= n_pid;
        r_pass2      <= n_pass2;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
    end

    assign o_in_ready      = (r_state == fptbl_pkg::ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_found_process = r_out_found;
    assign o_status        = r_out_status;

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the five-tuple flow to process table. Commands go in
// through the valid/ready input channel and each result word is compared with a
// local shadow of the flow table, updated as each command word is accepted.
// Directed edge cases, a fill-to-full pass and random traffic on a reused key
// pool run under different sender gap and receiver stall patterns.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FLOW_SLOTS = fptbl_pkg::TABLE_ENTRIES_DEF;
    localparam int POOL_SIZE = 100;
    localparam int EXP_DEPTH = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_LIMIT = 20_000;
    localparam int MAX_LOGGED = 40;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [fptbl_pkg::PROTO_W-1:0] PROTO_TCP = 8'd6;

    typedef struct {
        logic [1:0]                  op;
        fptbl_pkg::t_key             key;
        logic [fptbl_pkg::PID_W-1:0] pid;
    } t_flow_cmd;

    typedef struct {
        logic [fptbl_pkg::PID_W-1:0] found;
        logic [1:0]                  status;
    } t_flow_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_operation = '0;
    logic [7:0]        i_protocol = '0;
    logic [63:0]       i_local_addr_high = '0;
    logic [63:0]       i_local_addr_low = '0;
    logic [15:0]       i_local_port = '0;
    logic [63:0]       i_remote_addr_high = '0;
    logic [63:0]       i_remote_addr_low = '0;
    logic [15:0]       i_remote_port = '0;
    logic [31:0]       i_process_id = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [31:0]       o_found_process;
    logic [1:0]        o_status;

    // shadow of the flow table
    logic                        shadow_valid [FLOW_SLOTS];
    fptbl_pkg::t_key             shadow_key [FLOW_SLOTS];
    logic [fptbl_pkg::PID_W-1:0] shadow_pid [FLOW_SLOTS];

    // expected result words, in order
    t_flow_result    expected_results [EXP_DEPTH];
    int              exp_wr_cnt = 0;
    int              exp_rd_cnt = 0;
    t_flow_result    next_result;
    fptbl_pkg::t_key key_pool [POOL_SIZE];
    int              pool_count = 0;

    int error_count = 0;
    int cycle_count = 0;
    int burst_gap_max = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_run = 0;
    bit stall_now = 1'b0;

    flow_to_process_table u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_operation        (i_operation),
        .i_protocol         (i_protocol),
        .i_local_addr_high  (i_local_addr_high),
        .i_local_addr_low   (i_local_addr_low),
        .i_local_port       (i_local_port),
        .i_remote_addr_high (i_remote_addr_high),
        .i_remote_addr_low  (i_remote_addr_low),
        .i_remote_port      (i_remote_port),
        .i_process_id       (i_process_id),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_found_process    (o_found_process),
        .o_status           (o_status)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        // keep the log short when everything goes wrong
        if (error_count < MAX_LOGGED) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endtask

    function automatic int find_flow(input fptbl_pkg::t_key k);
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (shadow_valid[i] && shadow_key[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int flows_held();
        int n;
        n = 0;
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            n += shadow_valid[i];
        end
        return n;
    endfunction

    function automatic t_flow_result predict_flow_op(input t_flow_cmd c);
        t_flow_result r;
        fptbl_pkg::t_key wild;
        int idx;
        r.found = '0;
        r.status = fptbl_pkg::STS_MISS;
        idx = find_flow(c.key);
        case (c.op)
            fptbl_pkg::OP_INSERT: begin
                // new keys take the lowest free slot
                for (int i = 0; i < FLOW_SLOTS && idx < 0; i++) begin
                    if (!shadow_valid[i]) begin
                        idx = i;
                    end
                end
                if (idx < 0) begin
                    r.status = fptbl_pkg::STS_FULL;
                end else begin
                    shadow_valid[idx] = 1'b1;
                    shadow_key[idx] = c.key;
                    shadow_pid[idx] = c.pid;
                    r.status = fptbl_pkg::STS_OK;
                end
            end
            fptbl_pkg::OP_REMOVE: begin
                if (idx >= 0) begin
                    shadow_valid[idx] = 1'b0;
                    r.status = fptbl_pkg::STS_OK;
                end
            end
            fptbl_pkg::OP_LOOKUP: begin
                // udp falls back to a wildcard remote side
                if (idx < 0 && c.key.protocol == fptbl_pkg::PROTO_UDP) begin
                    wild = c.key;
                    wild.remote_high = '0;
                    wild.remote_low = '0;
                    wild.remote_port = '0;
                    idx = find_flow(wild);
                end
                if (idx >= 0) begin
                    r.found = shadow_pid[idx];
                    r.status = fptbl_pkg::STS_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic fptbl_pkg::t_key random_flow_key();
        fptbl_pkg::t_key k;
        int r;
        r = $urandom_range(0, 9);
        k.protocol = (r < 4) ? fptbl_pkg::PROTO_UDP : (r < 7) ? PROTO_TCP : 8'($urandom);
        k.local_high = {$urandom, $urandom};
        k.local_low = {$urandom, $urandom};
        k.local_port = 16'($urandom);
        k.remote_high = {$urandom, $urandom};
        k.remote_low = {$urandom, $urandom};
        k.remote_port = 16'($urandom);
        if (k.protocol == fptbl_pkg::PROTO_UDP && $urandom_range(0, 3) == 0) begin
            k.remote_high = '0;
            k.remote_low = '0;
            k.remote_port = '0;
        end
        return k;
    endfunction

    // drive one command word, hold it until taken, then predict its result
    task automatic send_flow_cmd(input t_flow_cmd c);
        int gap;
        if (burst_gap_max != 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, burst_gap_max);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_operation <= c.op;
        i_protocol <= c.key.protocol;
        i_local_addr_high <= c.key.local_high;
        i_local_addr_low <= c.key.local_low;
        i_local_port <= c.key.local_port;
        i_remote_addr_high <= c.key.remote_high;
        i_remote_addr_low <= c.key.remote_low;
        i_remote_port <= c.key.remote_port;
        i_process_id <= c.pid;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results[exp_wr_cnt % EXP_DEPTH] = predict_flow_op(c);
        exp_wr_cnt++;
    endtask

    // receiver: always ready, random stalls, or long ready/stall runs
    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: begin
                if (stall_run == 0) begin
                    stall_now = ~stall_now;
                    stall_run = stall_now ? $urandom_range(1, 30) : $urandom_range(1, 12);
                end
                stall_run--;
                i_out_ready <= ~stall_now;
            end
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_wr_cnt == exp_rd_cnt) begin
                report_mismatch($sformatf("unexpected result word: process %0h status %0d",
                                          o_found_process, o_status));
            end else begin
                next_result = expected_results[exp_rd_cnt % EXP_DEPTH];
                exp_rd_cnt++;
                if (o_found_process !== next_result.found) begin
                    report_mismatch($sformatf("found_process %0h, expected %0h",
                                              o_found_process, next_result.found));
                end
                if (o_status !== next_result.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, next_result.status));
                end
            end
        end
    end

    task automatic test_directed_edges();
        t_flow_cmd zero_cmd, ones_cmd, wild_cmd, exact_cmd, c;
        burst_gap_max = 0;
        stall_mode = 0;
        zero_cmd.op = fptbl_pkg::OP_LOOKUP;
        zero_cmd.key = '0;
        zero_cmd.pid = '0;
        ones_cmd.op = fptbl_pkg::OP_INSERT;
        ones_cmd.key = '1;
        ones_cmd.pid = '1;

        // empty table: everything misses
        send_flow_cmd(zero_cmd);
        zero_cmd.op = fptbl_pkg::OP_REMOVE;
        send_flow_cmd(zero_cmd);
        zero_cmd.op = OP_UNUSED;
        send_flow_cmd(zero_cmd);

        // entry holding process 0 still counts as a hit
        zero_cmd.op = fptbl_pkg::OP_INSERT;
        send_flow_cmd(zero_cmd);
        zero_cmd.op = fptbl_pkg::OP_LOOKUP;
        send_flow_cmd(zero_cmd);

        // all-ones key, then overwrite of a present key
        send_flow_cmd(ones_cmd);
        ones_cmd.op = fptbl_pkg::OP_LOOKUP;
        send_flow_cmd(ones_cmd);
        ones_cmd.op = fptbl_pkg::OP_INSERT;
        ones_cmd.pid = 32'h5a5a_0001;
        send_flow_cmd(ones_cmd);
        ones_cmd.op = fptbl_pkg::OP_LOOKUP;
        send_flow_cmd(ones_cmd);

        // udp wildcard entry: remote side zero
        wild_cmd.op = fptbl_pkg::OP_INSERT;
        wild_cmd.key = random_flow_key();
        wild_cmd.key.protocol = fptbl_pkg::PROTO_UDP;
        wild_cmd.key.remote_high = '0;
        wild_cmd.key.remote_low = '0;
        wild_cmd.key.remote_port = '0;
        wild_cmd.pid = $urandom;
        send_flow_cmd(wild_cmd);
        exact_cmd = wild_cmd;
        exact_cmd.key.remote_high = {$urandom, $urandom};
        exact_cmd.key.remote_low = {$urandom, $urandom};
        exact_cmd.key.remote_port = 16'($urandom) | 16'h1;
        c = exact_cmd;
        c.op = fptbl_pkg::OP_LOOKUP;
        send_flow_cmd(c);
        // same key as tcp has no fallback
        c.key.protocol = PROTO_TCP;
        send_flow_cmd(c);

        // exact udp entry wins over the wildcard
        exact_cmd.pid = $urandom;
        send_flow_cmd(exact_cmd);
        c = exact_cmd;
        c.op = fptbl_pkg::OP_LOOKUP;
        send_flow_cmd(c);

        // udp key whose remote side is already zero, not present
        c = wild_cmd;
        c.op = fptbl_pkg::OP_LOOKUP;
        c.key.local_port = ~c.key.local_port;
        send_flow_cmd(c);

        wild_cmd.op = fptbl_pkg::OP_REMOVE;
        send_flow_cmd(wild_cmd);
        c = exact_cmd;
        c.op = fptbl_pkg::OP_LOOKUP;
        c.key.remote_port = ~c.key.remote_port;
        send_flow_cmd(c);
        c.key.remote_port = exact_cmd.key.remote_port;
        send_flow_cmd(c);

        // remove twice: second one misses
        ones_cmd.op = fptbl_pkg::OP_REMOVE;
        send_flow_cmd(ones_cmd);
        send_flow_cmd(ones_cmd);
        ones_cmd.op = OP_UNUSED;
        ones_cmd.pid = '1;
        send_flow_cmd(ones_cmd);
        ones_cmd.op = fptbl_pkg::OP_LOOKUP;
        send_flow_cmd(ones_cmd);

        zero_cmd.op = fptbl_pkg::OP_REMOVE;
        send_flow_cmd(zero_cmd);
        exact_cmd.op = fptbl_pkg::OP_REMOVE;
        send_flow_cmd(exact_cmd);
    endtask

    task automatic test_table_full();
        t_flow_cmd c;
        fptbl_pkg::t_key held_keys [FLOW_SLOTS];
        int held_count;
        int slot;
        held_count = 0;
        burst_gap_max = 6;
        stall_mode = 1;
        while (flows_held() < FLOW_SLOTS) begin
            c.op = fptbl_pkg::OP_INSERT;
            c.key = random_flow_key();
            c.pid = $urandom;
            send_flow_cmd(c);
        end
        // refused inserts into a full table
        repeat (3) begin
            c.key = random_flow_key();
            send_flow_cmd(c);
        end
        // overwrite still works when full
        slot = $urandom_range(0, FLOW_SLOTS - 1);
        c.key = shadow_key[slot];
        c.pid = $urandom;
        send_flow_cmd(c);
        c.op = fptbl_pkg::OP_LOOKUP;
        send_flow_cmd(c);
        // free a few slots and refill them
        repeat (4) begin
            c.op = fptbl_pkg::OP_REMOVE;
            c.key = shadow_key[$urandom_range(0, FLOW_SLOTS - 1)];
            send_flow_cmd(c);
            c.op = fptbl_pkg::OP_INSERT;
            c.key = random_flow_key();
            c.pid = $urandom;
            send_flow_cmd(c);
        end
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            if (shadow_valid[i]) begin
                held_keys[held_count] = shadow_key[i];
                held_count++;
            end
        end
        c.op = fptbl_pkg::OP_REMOVE;
        for (int i = 0; i < held_count; i++) begin
            c.key = held_keys[i];
            send_flow_cmd(c);
        end
    endtask

    task automatic test_random_traffic(input int count, input int gap_max, input int rx_mode);
        t_flow_cmd c;
        fptbl_pkg::t_key k;
        int roll;
        int held;
        bit filling;
        burst_gap_max = gap_max;
        stall_mode = rx_mode;
        // pool of keys, many of them near misses of a neighbor
        while (pool_count < POOL_SIZE) begin
            if (pool_count != 0 && $urandom_range(0, 9) < 3) begin
                k = key_pool[pool_count - 1];
                case ($urandom_range(0, 6))
                    0: k.protocol[$urandom_range(0, fptbl_pkg::PROTO_W - 1)] ^= 1'b1;
                    1: k.local_high = {$urandom, $urandom};
                    2: k.local_low = {$urandom, $urandom};
                    3: k.local_port = 16'($urandom);
                    4: k.remote_high = {$urandom, $urandom};
                    5: k.remote_low = {$urandom, $urandom};
                    default: k.remote_port = 16'($urandom);
                endcase
            end else begin
                k = random_flow_key();
            end
            key_pool[pool_count] = k;
            pool_count++;
        end
        filling = 1'b1;
        repeat (count) begin
            // swing between filling the table up and draining it
            held = flows_held();
            if (filling && held == FLOW_SLOTS && $urandom_range(0, 7) == 0) begin
                filling = 1'b0;
            end else if (!filling && held < 6) begin
                filling = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                c.op = OP_UNUSED;
            end else if (roll < (filling ? 53 : 18)) begin
                c.op = fptbl_pkg::OP_INSERT;
            end else if (roll < (filling ? 68 : 63)) begin
                c.op = fptbl_pkg::OP_REMOVE;
            end else begin
                c.op = fptbl_pkg::OP_LOOKUP;
            end
            if ($urandom_range(0, 9) == 0) begin
                c.key = random_flow_key();
            end else begin
                c.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            if (c.op == fptbl_pkg::OP_LOOKUP && c.key.protocol == fptbl_pkg::PROTO_UDP &&
                    $urandom_range(0, 2) == 0) begin
                c.key.remote_high = {$urandom, $urandom};
                c.key.remote_low = {$urandom, $urandom};
                c.key.remote_port = 16'($urandom);
            end
            c.pid = ($urandom_range(0, 15) == 0) ? '0 : $urandom;
            send_flow_cmd(c);
        end
    endtask

    initial begin
        int waited;
        for (int i = 0; i < FLOW_SLOTS; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i] = '0;
            shadow_pid[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_table_full();
        test_random_traffic(200, 0, 0);
        test_random_traffic(200, 8, 0);
        test_random_traffic(200, 0, 2);
        test_random_traffic(200, 20, 1);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        waited = 0;
        while (exp_wr_cnt != exp_rd_cnt && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (300) @(posedge i_clk);
        if (exp_wr_cnt != exp_rd_cnt) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      exp_wr_cnt - exp_rd_cnt));
        end

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- flow_to_process_table.f -----
src/fptbl_pkg.sv
src/flow_to_process_table.sv
tb/testbench.sv
